// File: rtl/bpl_pkg.sv
// Shared types and constants for the bounded position list.
package bpl_pkg;

	// Fixed field widths of the command and result beats
	localparam int CMD_W   = 3;
	localparam int DATA_W  = 8;
	localparam int INDEX_W = 8;
	localparam int COUNT_W = 9;
	localparam int ERR_W   = 2;

	// Command codes; code seven is unused and does nothing
	typedef enum logic [CMD_W-1:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_INS_TAIL = 3'd1,
		CMD_REM_HEAD = 3'd2,
		CMD_REM_TAIL = 3'd3,
		CMD_RD_HEAD  = 3'd4,
		CMD_RD_TAIL  = 3'd5,
		CMD_RD_INDEX = 3'd6
	} cmd_t;

	// Error codes returned with every result
	typedef enum logic [ERR_W-1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2,
		ERR_RANGE = 2'd3
	} err_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_SHIFT,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Operations on the read pointer
	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_ZERO,
		PTR_ONE,
		PTR_TAIL,
		PTR_INDEX,
		PTR_INC,
		PTR_DEC
	} ptr_op_t;

	// Operations on the live count
	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	// Where a new entry is written
	typedef enum logic [1:0] {
		PUT_NONE,
		PUT_HEAD,
		PUT_TAIL
	} put_t;

	// One stored entry
	typedef struct packed {
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] symbol;
	} entry_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic    load;
		logic    rd_en;
		logic    shift_wr;
		logic    shift_up;
		ptr_op_t ptr_op;
		logic    finish;
		cnt_op_t cnt_op;
		put_t    put;
		logic    take_read;
		err_t    err;
	} ctrl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic empty;
		logic idx_bad;
		logic ptr_zero;
		logic ptr_limit;
	} stat_t;

endpackage

// File: rtl/bpl_datapath.sv
// Datapath of the bounded position list: entry memory, counts, pointer and result registers.
module bpl_datapath #(
	parameter int CAPACITY = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bpl_pkg::CMD_W-1:0]    command,
	input  logic [bpl_pkg::DATA_W-1:0]   pos_x,
	input  logic [bpl_pkg::DATA_W-1:0]   pos_y,
	input  logic [bpl_pkg::DATA_W-1:0]   pos_symbol,
	input  logic [bpl_pkg::INDEX_W-1:0]  read_index,
	input  bpl_pkg::ctrl_t               ctl,
	output bpl_pkg::stat_t               stat,
	output logic                         done,
	output logic [bpl_pkg::DATA_W-1:0]   out_x,
	output logic [bpl_pkg::DATA_W-1:0]   out_y,
	output logic [bpl_pkg::DATA_W-1:0]   out_symbol,
	output logic [bpl_pkg::COUNT_W-1:0]  entry_count,
	output logic [bpl_pkg::ERR_W-1:0]    error_code
);
	import bpl_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;
	localparam logic [AW-1:0] LAST_ADDR  = AW'(CAPACITY - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

	cmd_t                cmd_q;
	entry_t              item_q;
	logic [INDEX_W-1:0]  index_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       fill_q;
	logic [AW-1:0]       ptr_q;
	entry_t              mem [CAPACITY];
	entry_t              rdata_s1;
	logic                blank_s1;
	logic                wr_pend_s1;
	logic [AW-1:0]       wr_addr_s1;
	logic                done_q;
	entry_t              out_q;
	logic [COUNT_W-1:0]  entry_count_q;
	err_t                error_q;

	logic                full;
	logic                empty;
	logic [AW-1:0]       limit;
	logic [AW-1:0]       tail_addr;
	entry_t              read_word;
	logic [CW-1:0]       new_count;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	entry_t              wr_data;

	// Conditions on the live count and the requested index
	assign full      = (count_q == FULL_COUNT);
	assign empty     = (count_q == '0);
	assign limit     = full ? LAST_ADDR : AW'(count_q);
	assign tail_addr = AW'(count_q - CW'(1));

	assign stat.cmd       = cmd_q;
	assign stat.full      = full;
	assign stat.empty     = empty;
	assign stat.idx_bad   = (IW'(index_q) >= IW'(CAPACITY));
	assign stat.ptr_zero  = (ptr_q == '0);
	assign stat.ptr_limit = (ptr_q == limit);

	// A cell at or beyond the fill mark has never been written and reads as zero.
	assign read_word = blank_s1 ? '0 : rdata_s1;

	// Count after the command completes
	always_comb begin
		case (ctl.cnt_op)
			CNT_INC: new_count = count_q + CW'(1);
			CNT_DEC: new_count = count_q - CW'(1);
			default: new_count = count_q;
		endcase
	end

	// Single write port: shift copies take priority, new entries are written at finish.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wr_addr_s1;
		wr_data = read_word;
		if (wr_pend_s1) begin
			wr_en = 1'b1;
		end else if (ctl.finish && (ctl.put != PUT_NONE)) begin
			wr_en   = 1'b1;
			wr_addr = (ctl.put == PUT_HEAD) ? '0 : AW'(count_q);
			wr_data = item_q;
		end
	end

	// Entry memory with a registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_s1   <= mem[ptr_q];
			blank_s1   <= (CW'(ptr_q) >= fill_q);
			wr_addr_s1 <= ctl.shift_up ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
		end
	end

	// Latch the command beat on acceptance
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q         <= cmd_t'(command);
			item_q.x      <= pos_x;
			item_q.y      <= pos_y;
			item_q.symbol <= pos_symbol;
			index_q       <= read_index;
		end
	end

	// Read pointer
	always_ff @(posedge clk) begin
		case (ctl.ptr_op)
			PTR_ZERO:  ptr_q <= '0;
			PTR_ONE:   ptr_q <= AW'(1);
			PTR_TAIL:  ptr_q <= tail_addr;
			PTR_INDEX: ptr_q <= AW'(index_q);
			PTR_INC:   ptr_q <= ptr_q + AW'(1);
			PTR_DEC:   ptr_q <= ptr_q - AW'(1);
			default:   ptr_q <= ptr_q;
		endcase
	end

	// Live count, fill mark, pending copy and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			fill_q     <= '0;
			wr_pend_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			wr_pend_s1 <= ctl.rd_en && ctl.shift_wr;
			done_q     <= ctl.finish;
			if (ctl.finish) begin
				count_q <= new_count;
				if ((ctl.cnt_op == CNT_INC) && (count_q == fill_q)) begin
					fill_q <= fill_q + CW'(1);
				end
			end
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			out_q         <= ctl.take_read ? read_word : '0;
			entry_count_q <= COUNT_W'(new_count);
			error_q       <= ctl.err;
		end
	end

	assign done        = done_q;
	assign out_x       = out_q.x;
	assign out_y       = out_q.y;
	assign out_symbol  = out_q.symbol;
	assign entry_count = entry_count_q;
	assign error_code  = error_q;

endmodule

// File: rtl/bpl_ctrl.sv
// Controller state machine of the bounded position list.
module bpl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bpl_pkg::stat_t stat,
	output bpl_pkg::ctrl_t ctl,
	output logic           busy
);
	import bpl_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   up;

	// Head removal walks upwards, head insertion walks downwards.
	assign up = (stat.cmd == CMD_REM_HEAD);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d       = state_q;
		ctl           = '0;
		ctl.ptr_op    = PTR_HOLD;
		ctl.cnt_op    = CNT_HOLD;
		ctl.put       = PUT_NONE;
		ctl.err       = ERR_OK;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_FINISH;
				case (stat.cmd)
					CMD_INS_HEAD: begin
						if (!stat.full && !stat.empty) begin
							ctl.ptr_op = PTR_TAIL;
							state_d    = ST_SHIFT;
						end
					end
					CMD_REM_HEAD: begin
						if (!stat.empty) begin
							ctl.ptr_op = PTR_ONE;
							state_d    = ST_SHIFT;
						end
					end
					CMD_RD_HEAD: begin
						if (!stat.empty) begin
							ctl.ptr_op = PTR_ZERO;
							state_d    = ST_READ;
						end
					end
					CMD_RD_TAIL: begin
						if (!stat.empty) begin
							ctl.ptr_op = PTR_TAIL;
							state_d    = ST_READ;
						end
					end
					CMD_RD_INDEX: begin
						if (!stat.idx_bad) begin
							ctl.ptr_op = PTR_INDEX;
							state_d    = ST_READ;
						end
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_READ: begin
				ctl.rd_en = 1'b1;
				state_d   = ST_FINISH;
			end
			// One cell is read and the previous one copied on each cycle.
			ST_SHIFT: begin
				ctl.rd_en    = 1'b1;
				ctl.shift_wr = 1'b1;
				ctl.shift_up = up;
				ctl.ptr_op   = up ? PTR_INC : PTR_DEC;
				if (up ? stat.ptr_limit : stat.ptr_zero) begin
					state_d = ST_DRAIN;
				end
			end
			// The last copy is written here.
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			// Commit the command and load the result registers.
			ST_FINISH: begin
				ctl.finish = 1'b1;
				state_d    = ST_IDLE;
				case (stat.cmd)
					CMD_INS_HEAD: begin
						if (stat.full) begin
							ctl.err = ERR_FULL;
						end else begin
							ctl.put    = PUT_HEAD;
							ctl.cnt_op = CNT_INC;
						end
					end
					CMD_INS_TAIL: begin
						if (stat.full) begin
							ctl.err = ERR_FULL;
						end else begin
							ctl.put    = PUT_TAIL;
							ctl.cnt_op = CNT_INC;
						end
					end
					CMD_REM_HEAD, CMD_REM_TAIL: begin
						if (stat.empty) begin
							ctl.err = ERR_EMPTY;
						end else begin
							ctl.cnt_op = CNT_DEC;
						end
					end
					CMD_RD_HEAD, CMD_RD_TAIL: begin
						if (stat.empty) begin
							ctl.err = ERR_EMPTY;
						end else begin
							ctl.take_read = 1'b1;
						end
					end
					CMD_RD_INDEX: begin
						if (stat.idx_bad) begin
							ctl.err = ERR_RANGE;
						end else begin
							ctl.take_read = 1'b1;
						end
					end
					default: begin
						ctl.err = ERR_OK;
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/bounded_position_list.sv
// Top level of the bounded position list: controller and datapath.
//
// A command beat is taken when start is high and busy is low. Its result beat appears on the
// result ports for one cycle with done high, in the first cycle in which busy is low again.
// The receiver cannot hold it off. All entries sit in one memory with a single write port and
// a registered read, so the cost of a command is set by how many cells it must touch through
// that port. Tail insert, tail remove, the unused code, every error case and head insert into
// an empty list pass through the decode and finish states only; head, tail and index reads also
// pass through the read state; head insert with n live entries shifts n cells through the
// shift state and head removal with n live entries shifts min(n, CAPACITY - 1) cells, each
// followed by the drain state. A new command may be taken in the same cycle as the previous
// result is shown. Cells that were never written are marked by a fill count and read as zero,
// so no clearing pass follows reset.
module bounded_position_list #(
	parameter int CAPACITY = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [bpl_pkg::CMD_W-1:0]    command,
	input  logic [bpl_pkg::DATA_W-1:0]   pos_x,
	input  logic [bpl_pkg::DATA_W-1:0]   pos_y,
	input  logic [bpl_pkg::DATA_W-1:0]   pos_symbol,
	input  logic [bpl_pkg::INDEX_W-1:0]  read_index,
	output logic                         done,
	output logic [bpl_pkg::DATA_W-1:0]   out_x,
	output logic [bpl_pkg::DATA_W-1:0]   out_y,
	output logic [bpl_pkg::DATA_W-1:0]   out_symbol,
	output logic [bpl_pkg::COUNT_W-1:0]  entry_count,
	output logic [bpl_pkg::ERR_W-1:0]    error_code
);
	import bpl_pkg::*;

	ctrl_t ctl;
	stat_t stat;

	// Sequencing of each command
	bpl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	// Storage, counts and result registers
	bpl_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (command),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_symbol  (pos_symbol),
		.read_index  (read_index),
		.ctl         (ctl),
		.stat        (stat),
		.done        (done),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_symbol  (out_symbol),
		.entry_count (entry_count),
		.error_code  (error_code)
	);

endmodule

// File: verif/bounded_position_list_tb.sv
// Self-checking testbench for the bounded position list: edge cases, then random swings.
`timescale 1ns / 100ps

module bounded_position_list_tb;
	import bpl_pkg::*;

	localparam int LIST_CAP = 256;
	localparam int RANDOM_ITEMS = 1525;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	// One expected or observed result beat
	typedef struct packed {
		logic [DATA_W-1:0]  x;
		logic [DATA_W-1:0]  y;
		logic [DATA_W-1:0]  symbol;
		logic [COUNT_W-1:0] count;
		err_t               err;
	} list_result_t;

	// Keeps a shadow copy of the list and the queue of results still owed by the block.
	class list_scoreboard;
		entry_t       cells [LIST_CAP];
		int unsigned  live;
		list_result_t pending [$];
		int unsigned  faults;

		function new();
			foreach (cells[i]) cells[i] = '0;
			live = 0;
			faults = 0;
		endfunction

		// Apply one accepted command beat to the shadow list and queue its result.
		function void note_command(logic [CMD_W-1:0] code, logic [DATA_W-1:0] x,
				logic [DATA_W-1:0] y, logic [DATA_W-1:0] sym, logic [INDEX_W-1:0] idx);
			list_result_t res;
			entry_t       fresh;
			logic         have_read;
			int unsigned  at;
			res = '0;
			res.err = ERR_OK;
			fresh.x = x;
			fresh.y = y;
			fresh.symbol = sym;
			have_read = 1'b0;
			at = 0;
			case (code)
				CMD_INS_HEAD: begin
					if (live >= LIST_CAP) begin
						res.err = ERR_FULL;
					end else begin
						for (int i = live; i > 0; i--) cells[i] = cells[i-1];
						cells[0] = fresh;
						live++;
					end
				end
				CMD_INS_TAIL: begin
					if (live >= LIST_CAP) begin
						res.err = ERR_FULL;
					end else begin
						cells[live] = fresh;
						live++;
					end
				end
				CMD_REM_HEAD: begin
					if (live == 0) begin
						res.err = ERR_EMPTY;
					end else begin
						// The last cell of a full list keeps its own value.
						for (int i = 0; i < live; i++)
							if (i + 1 < LIST_CAP) cells[i] = cells[i+1];
						live--;
					end
				end
				CMD_REM_TAIL: begin
					if (live == 0) res.err = ERR_EMPTY;
					else live--;
				end
				CMD_RD_HEAD: begin
					if (live == 0) begin
						res.err = ERR_EMPTY;
					end else begin
						have_read = 1'b1;
						at = 0;
					end
				end
				CMD_RD_TAIL: begin
					if (live == 0) begin
						res.err = ERR_EMPTY;
					end else begin
						have_read = 1'b1;
						at = live - 1;
					end
				end
				CMD_RD_INDEX: begin
					// Checked against capacity only, so stale cells are readable.
					if (int'(idx) >= LIST_CAP) begin
						res.err = ERR_RANGE;
					end else begin
						have_read = 1'b1;
						at = int'(idx);
					end
				end
				default: ;
			endcase
			if (have_read) begin
				res.x = cells[at].x;
				res.y = cells[at].y;
				res.symbol = cells[at].symbol;
			end
			res.count = live[COUNT_W-1:0];
			pending.push_back(res);
		endfunction

		function void compare_field(string field_name, logic [COUNT_W-1:0] want,
				logic [COUNT_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d, got %0d", $time, field_name, want, got);
				faults++;
			end
		endfunction

		// Compare one result beat with the oldest expectation.
		function void check_result(list_result_t got);
			list_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: result beat with none expected (count %0d, error %0d)",
					$time, got.count, got.err);
				faults++;
				return;
			end
			want = pending.pop_front();
			compare_field("out_x", COUNT_W'(want.x), COUNT_W'(got.x));
			compare_field("out_y", COUNT_W'(want.y), COUNT_W'(got.y));
			compare_field("out_symbol", COUNT_W'(want.symbol), COUNT_W'(got.symbol));
			compare_field("entry_count", want.count, got.count);
			compare_field("error_code", COUNT_W'(want.err), COUNT_W'(got.err));
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [CMD_W-1:0]    command = '0;
	logic [DATA_W-1:0]   pos_x = '0;
	logic [DATA_W-1:0]   pos_y = '0;
	logic [DATA_W-1:0]   pos_symbol = '0;
	logic [INDEX_W-1:0]  read_index = '0;
	logic                busy;
	logic                done;
	logic [DATA_W-1:0]   out_x;
	logic [DATA_W-1:0]   out_y;
	logic [DATA_W-1:0]   out_symbol;
	logic [COUNT_W-1:0]  entry_count;
	logic [ERR_W-1:0]    error_code;

	list_scoreboard book;
	int unsigned    burst_left = 0;
	int unsigned    sent = 0;

	bounded_position_list #(.CAPACITY(LIST_CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_symbol(pos_symbol),
		.read_index(read_index),
		.done(done),
		.out_x(out_x),
		.out_y(out_y),
		.out_symbol(out_symbol),
		.entry_count(entry_count),
		.error_code(error_code)
	);

	always #5 clk = ~clk;

	// Sample both handshakes at the rising edge; the result is checked before the new beat is noted.
	always @(posedge clk) begin
		list_result_t seen;
		seen.x = out_x;
		seen.y = out_y;
		seen.symbol = out_symbol;
		seen.count = entry_count;
		seen.err = err_t'(error_code);
		if (arst_n && done) book.check_result(seen);
		if (arst_n && start && !busy)
			book.note_command(command, pos_x, pos_y, pos_symbol, read_index);
	end

	// Drive one command beat and return at the edge that accepts it.
	// The sender works in bursts with idle gaps of random length in between.
	task automatic issue(input logic [CMD_W-1:0] code, input logic [DATA_W-1:0] x,
			input logic [DATA_W-1:0] y, input logic [DATA_W-1:0] sym,
			input logic [INDEX_W-1:0] idx);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		command <= code;
		pos_x <= x;
		pos_y <= y;
		pos_symbol <= sym;
		read_index <= idx;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		burst_left--;
		sent++;
	endtask

	// Choose a command leaning towards growing (+1), shrinking (-1) or neither (0).
	function automatic logic [CMD_W-1:0] pick_command(int lean);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (lean == 0) return CMD_W'($urandom_range(0, 7));
		if (r < 35) return (lean > 0) ? CMD_INS_HEAD : CMD_REM_HEAD;
		if (r < 70) return (lean > 0) ? CMD_INS_TAIL : CMD_REM_TAIL;
		if (r < 75) return (lean > 0) ? CMD_REM_HEAD : CMD_INS_HEAD;
		if (r < 80) return (lean > 0) ? CMD_REM_TAIL : CMD_INS_TAIL;
		if (r < 86) return CMD_RD_HEAD;
		if (r < 92) return CMD_RD_TAIL;
		if (r < 98) return CMD_RD_INDEX;
		return CMD_UNUSED;
	endfunction

	// Index for a read: often a live cell, as often any index, sometimes the extremes.
	function automatic logic [INDEX_W-1:0] pick_index();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 4 && book.live > 0) return INDEX_W'($urandom_range(0, book.live - 1));
		if (r < 8) return INDEX_W'($urandom);
		return (r == 8) ? '0 : '1;
	endfunction

	task automatic issue_random(int lean);
		issue(pick_command(lean), DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
			pick_index());
	endtask

	initial begin
		int unsigned target;
		int unsigned r;
		book = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list: every error on empty, reads of never-written cells and the unused code.
		issue(CMD_REM_HEAD, 8'h11, 8'h22, 8'h33, 8'h00);
		issue(CMD_REM_TAIL, 8'h11, 8'h22, 8'h33, 8'h00);
		issue(CMD_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
		issue(CMD_RD_TAIL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		issue(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h00);
		issue(CMD_RD_INDEX, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		issue(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		// Build a short list from both ends with extreme field values.
		issue(CMD_INS_TAIL, 8'hFF, 8'hFF, 8'hFF, 8'h00);
		issue(CMD_INS_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
		issue(CMD_INS_HEAD, 8'hA5, 8'h5A, 8'hC3, 8'h00);
		issue(CMD_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
		issue(CMD_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);
		issue(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h01);
		// Removals leave stale cells behind that index reads still return.
		issue(CMD_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
		issue(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h02);
		issue(CMD_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);
		issue(CMD_RD_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);
		issue(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h01);
		issue(CMD_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00);
		issue(CMD_REM_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
		issue(CMD_RD_HEAD, 8'h00, 8'h00, 8'h00, 8'h00);
		issue(CMD_INS_HEAD, 8'hFF, 8'h00, 8'hFF, 8'h00);
		issue(CMD_RD_INDEX, 8'h00, 8'h00, 8'h00, 8'h00);
		issue(CMD_REM_TAIL, 8'h00, 8'h00, 8'h00, 8'h00);

		// Random swings towards empty, full or a level between, then a loiter there.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 25) target = 0;
			else if (r < 60) target = LIST_CAP;
			else target = $urandom_range(1, LIST_CAP - 1);
			while (book.live != target && sent < RANDOM_ITEMS)
				issue_random((book.live < target) ? 1 : -1);
			repeat ($urandom_range(4, 24)) issue_random(0);
		end
		start <= 1'b0;

		// Drain the outstanding results, then allow a few cycles for stray beats.
		while (book.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (book.faults == 0 && book.pending.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#25000000;
		$display("%0t: timed out with %0d results outstanding", $time, book.pending.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
